// File: rtl/core/ctbn_pkg.sv
// Shared types and constants for the combined tree barrier node.
// No dependencies; used by ctbn_event, ctbn_result_queue and the top level.
`default_nettype none

package ctbn_pkg;

  // Limits applied to the node_count and thread_count registers
  localparam int MAX_NODES   = 1024;
  localparam int MAX_THREADS = 64;

  localparam int RANK_W    = 10;
  localparam int NODES_W   = 11;
  localparam int THREADS_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;
  localparam int MAX_RES   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_RANK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THREAD_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_LOCAL_ARRIVE = 2'd0,
    OP_CHILD_ARRIVE = 2'd1,
    OP_PARENT_WAKE  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NOTIFY_PARENT = 2'd0,
    ACT_WAKE_CHILD    = 2'd1,
    ACT_RELEASE       = 2'd2,
    ACT_UNEXPECTED    = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [RANK_W-1:0] target_node;
    logic              sense_value;
  } result_t;

  // All results caused by one event; entries 0..n-1 are meaningful
  typedef struct packed {
    logic [1:0]            n;
    result_t [MAX_RES-1:0] res;
  } packet_t;

endpackage

`default_nettype wire

// File: rtl/core/ctbn_event.sv
// Barrier state, configuration registers and per-event decode.
// Depends on ctbn_pkg. Produces at most one result packet per accepted event.
`default_nettype none

module ctbn_event (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic [1:0]                   opcode,
  input  wire logic [ctbn_pkg::RANK_W-1:0]  source_node,
  input  wire logic                         cfg_we,
  input  wire logic [ctbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ctbn_pkg::CFG_W-1:0]   cfg_data,
  output logic                              push,
  output ctbn_pkg::packet_t                 packet
);

  logic [ctbn_pkg::RANK_W-1:0]    node_rank, node_rank_next;
  logic [ctbn_pkg::NODES_W-1:0]   node_count, node_count_next;
  logic [ctbn_pkg::THREADS_W-1:0] thread_count, thread_count_next;

  logic [ctbn_pkg::THREADS_W-1:0] threads_left, threads_left_next;
  logic [3:0]                     child_pending, child_pending_next;
  logic                           local_complete, local_complete_next;
  logic                           awaiting_parent, awaiting_parent_next;
  logic                           release_sense, release_sense_next;

  logic [ctbn_pkg::NODES_W-1:0]   eff_n;
  logic [ctbn_pkg::THREADS_W-1:0] eff_t;
  logic [3:0]                     mask_cur;
  logic [12:0]                    child_base;
  logic [12:0]                    child_off;
  logic [11:0]                    wake1, wake2;
  logic                           wake1_ok, wake2_ok;
  logic [ctbn_pkg::RANK_W-1:0]    parent;
  logic                           new_sense;
  ctbn_pkg::packet_t              rel_pkt, notify_pkt, bad_pkt;
  ctbn_pkg::result_t              rel_res, wake1_res, wake2_res;

  function automatic logic [ctbn_pkg::NODES_W-1:0] eff_nodes(
    input logic [ctbn_pkg::NODES_W-1:0] cnt
  );
    if (int'(cnt) > ctbn_pkg::MAX_NODES) return ctbn_pkg::NODES_W'(ctbn_pkg::MAX_NODES);
    return cnt;
  endfunction

  function automatic logic [ctbn_pkg::THREADS_W-1:0] eff_threads(
    input logic [ctbn_pkg::THREADS_W-1:0] cnt
  );
    logic [ctbn_pkg::THREADS_W-1:0] t;
    t = (cnt == '0) ? ctbn_pkg::THREADS_W'(1) : cnt;
    if (int'(t) > ctbn_pkg::MAX_THREADS) return ctbn_pkg::THREADS_W'(ctbn_pkg::MAX_THREADS);
    return t;
  endfunction

  // Children 4r+1..4r+4 that lie below the effective node count
  function automatic logic [3:0] present_mask(
    input logic [ctbn_pkg::RANK_W-1:0]  rk,
    input logic [ctbn_pkg::NODES_W-1:0] en
  );
    logic [3:0] m;
    m = '0;
    for (int c = 0; c < 4; c++) begin
      m[c] = (({1'b0, rk, 2'b00} + 13'(c + 1)) < {2'b00, en});
    end
    return m;
  endfunction

  assign eff_n      = eff_nodes(node_count);
  assign eff_t      = eff_threads(thread_count);
  assign mask_cur   = present_mask(node_rank, eff_n);
  assign child_base = {1'b0, node_rank, 2'b00} + 13'd1;
  assign child_off  = {3'b000, source_node} - child_base;
  assign wake1      = {1'b0, node_rank, 1'b1};
  assign wake2      = {1'b0, node_rank, 1'b0} + 12'd2;
  assign wake1_ok   = wake1 < {1'b0, eff_n};
  assign wake2_ok   = wake2 < {1'b0, eff_n};
  assign parent     = (node_rank - ctbn_pkg::RANK_W'(1)) >> 2;
  assign new_sense  = ~release_sense;

  assign rel_res   = '{action: ctbn_pkg::ACT_RELEASE, target_node: '0, sense_value: new_sense};
  assign wake1_res = '{action: ctbn_pkg::ACT_WAKE_CHILD,
                       target_node: wake1[ctbn_pkg::RANK_W-1:0], sense_value: 1'b0};
  assign wake2_res = '{action: ctbn_pkg::ACT_WAKE_CHILD,
                       target_node: wake2[ctbn_pkg::RANK_W-1:0], sense_value: 1'b0};

  always_comb begin
    rel_pkt = '0;
    if (wake2_ok) begin
      rel_pkt.n      = 2'd3;
      rel_pkt.res[0] = wake1_res;
      rel_pkt.res[1] = wake2_res;
      rel_pkt.res[2] = rel_res;
    end else if (wake1_ok) begin
      rel_pkt.n      = 2'd2;
      rel_pkt.res[0] = wake1_res;
      rel_pkt.res[1] = rel_res;
    end else begin
      rel_pkt.n      = 2'd1;
      rel_pkt.res[0] = rel_res;
    end
    notify_pkt        = '0;
    notify_pkt.n      = 2'd1;
    notify_pkt.res[0] = '{action: ctbn_pkg::ACT_NOTIFY_PARENT, target_node: parent,
                          sense_value: 1'b0};
    bad_pkt           = '0;
    bad_pkt.n         = 2'd1;
    bad_pkt.res[0]    = '{action: ctbn_pkg::ACT_UNEXPECTED, target_node: '0,
                          sense_value: 1'b0};
  end

  always_comb begin
    logic       done;
    logic [3:0] bit_sel;
    node_rank_next       = node_rank;
    node_count_next      = node_count;
    thread_count_next    = thread_count;
    threads_left_next    = threads_left;
    child_pending_next   = child_pending;
    local_complete_next  = local_complete;
    awaiting_parent_next = awaiting_parent;
    release_sense_next   = release_sense;
    packet               = '0;
    done                 = 1'b0;
    bit_sel              = 4'b0001 << child_off[1:0];

    if (accept) begin
      unique case (ctbn_pkg::opcode_t'(opcode))
        ctbn_pkg::OP_LOCAL_ARRIVE: begin
          if (local_complete || awaiting_parent) begin
            packet = bad_pkt;
          end else begin
            if (threads_left <= ctbn_pkg::THREADS_W'(1)) begin
              threads_left_next   = '0;
              local_complete_next = 1'b1;
              done                = (child_pending == '0);
            end else begin
              threads_left_next = threads_left - ctbn_pkg::THREADS_W'(1);
            end
          end
        end
        ctbn_pkg::OP_CHILD_ARRIVE: begin
          if (({3'b000, source_node} < child_base) || (child_off >= 13'd4) ||
              ((child_pending & bit_sel) == '0)) begin
            packet = bad_pkt;
          end else begin
            child_pending_next = child_pending & ~bit_sel;
            done = local_complete && (child_pending_next == '0) && !awaiting_parent;
          end
        end
        ctbn_pkg::OP_PARENT_WAKE: begin
          if (!awaiting_parent) begin
            packet = bad_pkt;
          end else begin
            awaiting_parent_next = 1'b0;
            release_sense_next   = new_sense;
            packet               = rel_pkt;
          end
        end
        default: packet = bad_pkt;
      endcase

      // Round complete: rearm right away, then notify or (at the root) release
      if (done) begin
        threads_left_next   = eff_t;
        child_pending_next  = mask_cur;
        local_complete_next = 1'b0;
        if (node_rank != '0) begin
          awaiting_parent_next = 1'b1;
          packet               = notify_pkt;
        end else begin
          awaiting_parent_next = 1'b0;
          release_sense_next   = new_sense;
          packet               = rel_pkt;
        end
      end
    end

    if (cfg_we && (cfg_index == ctbn_pkg::CFG_NODE_RANK ||
                   cfg_index == ctbn_pkg::CFG_NODE_COUNT ||
                   cfg_index == ctbn_pkg::CFG_THREAD_COUNT)) begin
      unique case (cfg_index)
        ctbn_pkg::CFG_NODE_RANK:  node_rank_next  = cfg_data[ctbn_pkg::RANK_W-1:0];
        ctbn_pkg::CFG_NODE_COUNT: node_count_next = cfg_data[ctbn_pkg::NODES_W-1:0];
        default:                  thread_count_next = cfg_data[ctbn_pkg::THREADS_W-1:0];
      endcase
      threads_left_next    = eff_threads(thread_count_next);
      child_pending_next   = present_mask(node_rank_next, eff_nodes(node_count_next));
      local_complete_next  = 1'b0;
      awaiting_parent_next = 1'b0;
    end
  end

  assign push = accept && (packet.n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_rank       <= '0;
      node_count      <= ctbn_pkg::NODES_W'(1);
      thread_count    <= ctbn_pkg::THREADS_W'(1);
      threads_left    <= ctbn_pkg::THREADS_W'(1);
      child_pending   <= '0;
      local_complete  <= 1'b0;
      awaiting_parent <= 1'b0;
      release_sense   <= 1'b1;
    end else begin
      node_rank       <= node_rank_next;
      node_count      <= node_count_next;
      thread_count    <= thread_count_next;
      threads_left    <= threads_left_next;
      child_pending   <= child_pending_next;
      local_complete  <= local_complete_next;
      awaiting_parent <= awaiting_parent_next;
      release_sense   <= release_sense_next;
    end
  end

  // The root never waits on a parent
  a_root_never_waits: assert property (@(posedge clk) disable iff (rst)
    awaiting_parent |-> (node_rank != '0))
    else $error("awaiting parent at root");

  a_done_vs_waiting: assert property (@(posedge clk) disable iff (rst)
    !(local_complete && awaiting_parent))
    else $error("local threads complete while awaiting parent");

  a_count_tracks_done: assert property (@(posedge clk) disable iff (rst)
    (threads_left == '0) == local_complete)
    else $error("thread count out of step with local_complete");

endmodule

`default_nettype wire

// File: rtl/core/ctbn_result_queue.sv
// Two-packet result queue; emits one result per output beat, tlast on the final one.
// Depends on ctbn_pkg.
`default_nettype none

module ctbn_result_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ctbn_pkg::packet_t packet,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ctbn_pkg::result_t      out_res,
  output logic                   out_last
);

  ctbn_pkg::packet_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic [1:0] idx;
  logic       beat, pop;

  assign room      = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_res   = slots[rd_ptr].res[idx];
  assign out_last  = (idx == slots[rd_ptr].n - 2'd1);
  assign beat      = out_valid && out_ready;
  assign pop       = beat && out_last;

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (!push && pop) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= packet;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      idx    <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        idx    <= '0;
      end else if (beat) begin
        idx <= idx + 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (room || pop))
    else $error("push into full result queue");

  a_idx_in_packet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx < slots[rd_ptr].n))
    else $error("result index past end of packet");

endmodule

`default_nettype wire

// File: rtl/core/combined_tree_barrier_node.sv
// Top level of one combined tree barrier node (4-ary arrival, binary wake-up).
// Depends on ctbn_pkg, ctbn_event and ctbn_result_queue.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tuser: opcode; tdata: source_node
//   m_axis    out  tvalid/tready, tlast   tuser: action; tdata: target_node, sense_value
//   cfg       in   cfg_we                 cfg_index, cfg_data (no read-back)
//
// An event is decoded and the state updated in the cycle it is accepted; its results
// queue behind earlier packets and go out on m_axis one per beat (0 to 3 per event).
// s_axis takes one event per cycle while fewer than two result packets are queued;
// an event with k results holds the output for k beats; quiet events queue nothing.
// Synchronous reset; config writes rearm the round and keep the release sense.
`default_nettype none

module combined_tree_barrier_node (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] source_node, [15:10] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [9:0] target_node, [10] sense_value, [15:11] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] action
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  logic              accept;
  logic              push;
  logic              room;
  ctbn_pkg::packet_t packet;
  ctbn_pkg::result_t out_res;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  ctbn_event u_event (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (s_axis_tuser),
    .source_node (s_axis_tdata[ctbn_pkg::RANK_W-1:0]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .packet      (packet)
  );

  ctbn_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .packet    (packet),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b00000, out_res.sense_value, out_res.target_node};
  assign m_axis_tuser = out_res.action;

endmodule

`default_nettype wire
